// ===== design/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// wbps_pkg
// Types, codes and the control program of the work/break phase sequencer.
// ----------------------------------------------------------------------------
package wbps_pkg;

  localparam int TimeW      = 32;
  localparam int MaxPhases  = 16;
  localparam int EffMax     = (MaxPhases < 16) ? MaxPhases : 16;
  localparam int MaxResults = 48;
  localparam int PcW        = 5;
  localparam int MinW       = 10;
  localparam int DurW       = 16;

  typedef logic [TimeW-1:0] secs_t;
  typedef logic [PcW-1:0]   pc_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'd0,
    ST_FOCUS  = 3'd1,
    ST_SHORT  = 3'd2,
    ST_LONG   = 3'd3,
    ST_PAUSED = 3'd4,
    ST_DONE   = 3'd5
  } state_e;

  typedef enum logic [1:0] {
    K_STARTED   = 2'd0,
    K_COMPLETED = 2'd1,
    K_PROMPT    = 2'd2,
    K_STATUS    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_PAUSE  = 3'd1,
    OP_RESUME = 3'd2,
    OP_SKIP   = 3'd3,
    OP_TICK   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    CFG_FOCUS      = 3'd0,
    CFG_SHORT      = 3'd1,
    CFG_LONG       = 3'd2,
    CFG_LONG_EVERY = 3'd3,
    CFG_COUNT      = 3'd4,
    CFG_PROMPT     = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    A_NOP,
    A_START_FOCUS,
    A_DONE,
    A_BREAK,
    A_PROMPT,
    A_NEXT_FOCUS,
    A_PAUSE,
    A_RESUME,
    A_UNPAUSE,
    A_STATUS
  } act_e;

  typedef enum logic [3:0] {
    C_ALWAYS,
    C_NOT_IDLE,
    C_COUNT_ZERO,
    C_NOT_TIMED,
    C_NOT_PAUSED,
    C_REPLAY_DONE,
    C_NOT_FOCUS,
    C_LAST_WORK,
    C_NO_PROMPT
  } cond_e;

  typedef enum logic {
    AT_NOW,
    AT_END
  } at_sel_e;

  typedef struct packed {
    act_e    act;
    cond_e   cond;
    at_sel_e at_sel;
    pc_t     target;
  } uword_t;

  typedef struct packed {
    logic not_idle;
    logic count_zero;
    logic not_timed;
    logic not_paused;
    logic replay_done;
    logic not_focus;
    logic last_work;
    logic no_prompt;
  } flags_t;

  typedef struct packed {
    logic    exec;
    logic    emit;
    act_e    act;
    at_sel_e at_sel;
  } ctrl_t;

  localparam pc_t PcStart  = 5'd0;
  localparam pc_t PcPause  = 5'd4;
  localparam pc_t PcResume = 5'd14;
  localparam pc_t PcSkip   = 5'd16;
  localparam pc_t PcReplay = 5'd24;
  localparam pc_t PcStatus = 5'd31;

  function automatic uword_t uw(act_e act, cond_e cond, at_sel_e at_sel, pc_t target);
    uword_t w;
    w.act    = act;
    w.cond   = cond;
    w.at_sel = at_sel;
    w.target = target;
    return w;
  endfunction

  // Condition tests read the registers as they stand before the step's action.
  function automatic uword_t ucode(pc_t pc);
    uword_t w;
    unique case (pc)
      5'd0:  w = uw(A_NOP,         C_NOT_IDLE,    AT_NOW, PcStatus);
      5'd1:  w = uw(A_NOP,         C_COUNT_ZERO,  AT_NOW, 5'd3);
      5'd2:  w = uw(A_START_FOCUS, C_ALWAYS,      AT_NOW, PcReplay);
      5'd3:  w = uw(A_DONE,        C_ALWAYS,      AT_NOW, PcStatus);
      5'd4:  w = uw(A_NOP,         C_NOT_TIMED,   AT_NOW, PcStatus);
      5'd5:  w = uw(A_NOP,         C_REPLAY_DONE, AT_END, 5'd12);
      5'd6:  w = uw(A_NOP,         C_NOT_FOCUS,   AT_END, 5'd10);
      5'd7:  w = uw(A_NOP,         C_LAST_WORK,   AT_END, 5'd11);
      5'd8:  w = uw(A_BREAK,       C_NO_PROMPT,   AT_END, 5'd5);
      5'd9:  w = uw(A_PROMPT,      C_ALWAYS,      AT_END, 5'd5);
      5'd10: w = uw(A_NEXT_FOCUS,  C_ALWAYS,      AT_END, 5'd5);
      5'd11: w = uw(A_DONE,        C_ALWAYS,      AT_END, 5'd5);
      5'd12: w = uw(A_NOP,         C_NOT_TIMED,   AT_NOW, PcStatus);
      5'd13: w = uw(A_PAUSE,       C_ALWAYS,      AT_NOW, PcStatus);
      5'd14: w = uw(A_NOP,         C_NOT_PAUSED,  AT_NOW, PcStatus);
      5'd15: w = uw(A_RESUME,      C_ALWAYS,      AT_NOW, PcReplay);
      5'd16: w = uw(A_UNPAUSE,     C_ALWAYS,      AT_NOW, 5'd17);
      5'd17: w = uw(A_NOP,         C_NOT_TIMED,   AT_NOW, PcStatus);
      5'd18: w = uw(A_NOP,         C_NOT_FOCUS,   AT_NOW, 5'd22);
      5'd19: w = uw(A_NOP,         C_LAST_WORK,   AT_NOW, 5'd23);
      5'd20: w = uw(A_BREAK,       C_NO_PROMPT,   AT_NOW, PcReplay);
      5'd21: w = uw(A_PROMPT,      C_ALWAYS,      AT_NOW, PcReplay);
      5'd22: w = uw(A_NEXT_FOCUS,  C_ALWAYS,      AT_NOW, PcReplay);
      5'd23: w = uw(A_DONE,        C_ALWAYS,      AT_NOW, PcReplay);
      5'd24: w = uw(A_NOP,         C_REPLAY_DONE, AT_END, PcStatus);
      5'd25: w = uw(A_NOP,         C_NOT_FOCUS,   AT_END, 5'd29);
      5'd26: w = uw(A_NOP,         C_LAST_WORK,   AT_END, 5'd30);
      5'd27: w = uw(A_BREAK,       C_NO_PROMPT,   AT_END, PcReplay);
      5'd28: w = uw(A_PROMPT,      C_ALWAYS,      AT_END, PcReplay);
      5'd29: w = uw(A_NEXT_FOCUS,  C_ALWAYS,      AT_END, PcReplay);
      5'd30: w = uw(A_DONE,        C_ALWAYS,      AT_END, PcReplay);
      5'd31: w = uw(A_STATUS,      C_ALWAYS,      AT_NOW, PcStatus);
    endcase
    return w;
  endfunction

  function automatic pc_t entry_pc(logic [2:0] op);
    pc_t pc;
    unique case (op)
      OP_START:  pc = PcStart;
      OP_PAUSE:  pc = PcPause;
      OP_RESUME: pc = PcResume;
      OP_SKIP:   pc = PcSkip;
      OP_TICK:   pc = PcReplay;
      default:   pc = PcStatus;
    endcase
    return pc;
  endfunction

  function automatic logic act_emits(act_e act);
    logic e;
    unique case (act)
      A_START_FOCUS, A_DONE, A_BREAK, A_PROMPT, A_NEXT_FOCUS, A_STATUS: e = 1'b1;
      default: e = 1'b0;
    endcase
    return e;
  endfunction

  // True when n is a nonzero multiple of e, for n up to 16 and e nonzero.
  function automatic logic is_multiple(logic [4:0] n, logic [3:0] e);
    logic       hit;
    logic [7:0] p;
    hit = 1'b0;
    for (int k = 1; k <= 16; k++) begin
      p = 8'(k) * {4'b0, e};
      if (p == {3'b0, n}) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

endpackage

// ===== design/wbps_cmd_if.sv =====
// ----------------------------------------------------------------------------
// wbps_cmd_if
// Command channel: operation code and the time stamp of the request.
// ----------------------------------------------------------------------------
interface wbps_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] now_seconds;

  modport source (output valid, output op, output now_seconds, input ready);
  modport sink (input valid, input op, input now_seconds, output ready);
endinterface

// ===== design/wbps_res_if.sv =====
// ----------------------------------------------------------------------------
// wbps_res_if
// Result channel: events and the closing status item of each request.
// ----------------------------------------------------------------------------
interface wbps_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [2:0]  phase_state;
  logic [3:0]  phase_index;
  logic [31:0] at_seconds;
  logic [31:0] remaining_seconds;
  logic        last;

  modport source (
    output valid, output kind, output phase_state, output phase_index,
    output at_seconds, output remaining_seconds, output last, input ready
  );
  modport sink (
    input valid, input kind, input phase_state, input phase_index,
    input at_seconds, input remaining_seconds, input last, output ready
  );
endinterface

// ===== design/wbps_seq_ctrl.sv =====
// ----------------------------------------------------------------------------
// wbps_seq_ctrl
// Step counter and program table: fetches one control word per cycle,
// tests its jump condition and holds while a result cannot be delivered.
// ----------------------------------------------------------------------------
module wbps_seq_ctrl
  import wbps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic [2:0] op_i,
  input  flags_t     flags_i,
  input  logic       out_free_i,
  output logic       busy_o,
  output ctrl_t      ctrl_o
);

  logic       busy_q, busy_d;
  pc_t        pc_q, pc_d;
  logic [5:0] emit_cnt_q, emit_cnt_d;
  uword_t     word;
  logic       emit_ok, want_emit, stall, step, jump;

  assign word      = ucode(pc_q);
  assign emit_ok   = emit_cnt_q < 6'(MaxResults);
  assign want_emit = busy_q && act_emits(word.act) && emit_ok;
  assign stall     = want_emit && !out_free_i;
  assign step      = busy_q && !stall;

  always_comb begin
    unique case (word.cond)
      C_ALWAYS:      jump = 1'b1;
      C_NOT_IDLE:    jump = flags_i.not_idle;
      C_COUNT_ZERO:  jump = flags_i.count_zero;
      C_NOT_TIMED:   jump = flags_i.not_timed;
      C_NOT_PAUSED:  jump = flags_i.not_paused;
      C_REPLAY_DONE: jump = flags_i.replay_done;
      C_NOT_FOCUS:   jump = flags_i.not_focus;
      C_LAST_WORK:   jump = flags_i.last_work;
      C_NO_PROMPT:   jump = flags_i.no_prompt;
      default:       jump = 1'b0;
    endcase
  end

  always_comb begin
    busy_d     = busy_q;
    pc_d       = pc_q;
    emit_cnt_d = emit_cnt_q;
    if (start_i) begin
      busy_d     = 1'b1;
      pc_d       = entry_pc(op_i);
      emit_cnt_d = '0;
    end else if (step) begin
      pc_d = jump ? word.target : pc_q + 5'd1;
      if (word.act == A_STATUS) begin
        busy_d = 1'b0;
      end
      if (want_emit) begin
        emit_cnt_d = emit_cnt_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      pc_q       <= PcStatus;
      emit_cnt_q <= '0;
    end else begin
      busy_q     <= busy_d;
      pc_q       <= pc_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  assign busy_o        = busy_q;
  assign ctrl_o.exec   = step;
  assign ctrl_o.emit   = step && want_emit;
  assign ctrl_o.act    = word.act;
  assign ctrl_o.at_sel = word.at_sel;

endmodule

// ===== design/work_break_phase_sequencer_unit.sv =====
// ----------------------------------------------------------------------------
// work_break_phase_sequencer_unit
// Work/break phase sequencer driven by a short microprogram.
// ----------------------------------------------------------------------------
// Each request runs a program of one step per clock cycle from a control
// table. Each phase whose end has already passed is replayed in turn. Every
// step that emits a result waits until the output register is free, so a
// stalled result channel stretches the request by the stall. A new request
// is accepted in the cycle after the status item of the previous one has
// been loaded into the output register.
module work_break_phase_sequencer_unit
  import wbps_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [2:0] cfg_idx_i,
  input  logic [9:0] cfg_data_i,
  wbps_cmd_if.sink   cmd_i,
  wbps_res_if.source res_o
);

  logic [MinW-1:0] focus_q, short_q, long_q;
  logic [3:0]      every_q;
  logic [4:0]      count_q;
  logic            prompt_q;

  state_e     state_q, state_d;
  logic [1:0] pf_q, pf_d;
  logic [3:0] wi_q, wi_d;
  secs_t      end_q, end_d;
  secs_t      pl_q, pl_d;
  secs_t      at_q, at_d;
  secs_t      now_q;

  logic        out_valid_q;
  kind_e       out_kind_q;
  state_e      out_state_q;
  logic [3:0]  out_index_q;
  secs_t       out_at_q, out_rem_q;
  logic        out_last_q;

  kind_e       o_kind;
  secs_t       o_at, o_rem;
  logic        o_last;

  flags_t          flags;
  ctrl_t           ctrl;
  logic            busy, start, out_free;
  logic            timed, lng;
  logic [4:0]      eff_count, next_work;
  logic [MinW-1:0] minutes;
  logic [DurW-1:0] dur_s;
  secs_t           at_src, add_a, add_b, sat, left;
  logic [TimeW:0]  sum;
  state_e          resume_st;

  assign start    = cmd_i.valid && cmd_i.ready;
  assign out_free = !out_valid_q || res_o.ready;
  assign cmd_i.ready = !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_q  <= 10'd25;
      short_q  <= 10'd5;
      long_q   <= 10'd15;
      every_q  <= 4'd4;
      count_q  <= 5'd4;
      prompt_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FOCUS:      focus_q  <= cfg_data_i;
        CFG_SHORT:      short_q  <= cfg_data_i;
        CFG_LONG:       long_q   <= cfg_data_i;
        CFG_LONG_EVERY: every_q  <= cfg_data_i[3:0];
        CFG_COUNT:      count_q  <= cfg_data_i[4:0];
        CFG_PROMPT:     prompt_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign timed     = (state_q == ST_FOCUS) || (state_q == ST_SHORT) || (state_q == ST_LONG);
  assign eff_count = (count_q > 5'(EffMax)) ? 5'(EffMax) : count_q;
  assign next_work = {1'b0, wi_q} + 5'd1;

  assign flags.not_idle    = state_q != ST_IDLE;
  assign flags.count_zero  = eff_count == 5'd0;
  assign flags.not_timed   = !timed;
  assign flags.not_paused  = state_q != ST_PAUSED;
  assign flags.replay_done = !timed || (now_q < end_q);
  assign flags.not_focus   = state_q != ST_FOCUS;
  assign flags.last_work   = next_work >= eff_count;
  assign flags.no_prompt   = !prompt_q;

  wbps_seq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_i       (cmd_i.op),
    .flags_i    (flags),
    .out_free_i (out_free),
    .busy_o     (busy),
    .ctrl_o     (ctrl)
  );

  assign lng     = (every_q != 4'd0) && is_multiple(next_work, every_q);
  assign minutes = (ctrl.act == A_BREAK) ? (lng ? long_q : short_q) : focus_q;
  assign dur_s   = DurW'({6'b0, minutes} * 16'd60);
  assign at_src  = (ctrl.at_sel == AT_NOW) ? now_q : end_q;
  assign add_a   = ((ctrl.act == A_START_FOCUS) || (ctrl.act == A_RESUME)) ? now_q : at_src;
  assign add_b   = (ctrl.act == A_RESUME) ? pl_q : {{(TimeW-DurW){1'b0}}, dur_s};
  assign sum     = {1'b0, add_a} + {1'b0, add_b};
  assign sat     = sum[TimeW] ? '1 : sum[TimeW-1:0];
  assign left    = (end_q > now_q) ? end_q - now_q : '0;
  assign resume_st = (pf_q != 2'd0) ? state_e'({1'b0, pf_q}) : ST_FOCUS;

  always_comb begin
    state_d = state_q;
    pf_d    = pf_q;
    wi_d    = wi_q;
    end_d   = end_q;
    pl_d    = pl_q;
    at_d    = at_q;
    o_kind  = K_STATUS;
    o_at    = now_q;
    o_rem   = '0;
    o_last  = 1'b0;
    if (ctrl.exec) begin
      unique case (ctrl.act)
        A_START_FOCUS: begin
          wi_d    = '0;
          state_d = ST_FOCUS;
          end_d   = sat;
          o_kind  = K_STARTED;
        end
        A_DONE: begin
          state_d = ST_DONE;
          o_kind  = K_COMPLETED;
          o_at    = at_src;
        end
        A_BREAK: begin
          state_d = lng ? ST_LONG : ST_SHORT;
          end_d   = sat;
          at_d    = at_src;
          o_kind  = K_STARTED;
          o_at    = at_src;
        end
        A_PROMPT: begin
          o_kind = K_PROMPT;
          o_at   = at_q;
        end
        A_NEXT_FOCUS: begin
          wi_d    = wi_q + 4'd1;
          state_d = ST_FOCUS;
          end_d   = sat;
          o_kind  = K_STARTED;
          o_at    = at_src;
        end
        A_PAUSE: begin
          pl_d    = left;
          pf_d    = state_q[1:0];
          state_d = ST_PAUSED;
        end
        A_RESUME: begin
          state_d = resume_st;
          end_d   = sat;
        end
        A_UNPAUSE: begin
          if (state_q == ST_PAUSED) begin
            state_d = resume_st;
          end
        end
        A_STATUS: begin
          o_last = 1'b1;
          unique case (state_q)
            ST_IDLE:                     o_rem = {{(TimeW-DurW){1'b0}}, dur_s};
            ST_PAUSED:                   o_rem = pl_q;
            ST_FOCUS, ST_SHORT, ST_LONG: o_rem = left;
            default:                     o_rem = '0;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pf_q    <= 2'(ST_FOCUS);
      wi_q    <= '0;
      end_q   <= '0;
      pl_q    <= '0;
    end else begin
      state_q <= state_d;
      pf_q    <= pf_d;
      wi_q    <= wi_d;
      end_q   <= end_d;
      pl_q    <= pl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    at_q <= at_d;
    if (start) begin
      now_q <= cmd_i.now_seconds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      out_kind_q  <= o_kind;
      out_state_q <= state_d;
      out_index_q <= wi_d;
      out_at_q    <= o_at;
      out_rem_q   <= o_rem;
      out_last_q  <= o_last;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.kind              = out_kind_q;
  assign res_o.phase_state       = out_state_q;
  assign res_o.phase_index       = out_index_q;
  assign res_o.at_seconds        = out_at_q;
  assign res_o.remaining_seconds = out_rem_q;
  assign res_o.last              = out_last_q;

`ifndef SYNTHESIS
  a_last_is_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.last |-> res_o.kind == K_STATUS)
    else $error("last flag on a result that is not a status item");

  a_prompt_on_break: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.kind == K_PROMPT |->
      res_o.phase_state == ST_SHORT || res_o.phase_state == ST_LONG)
    else $error("exercise prompt outside a break");

  a_paused_from_timed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pf_q != 2'd0)
    else $error("paused phase is not a timed phase");

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start |=> !cmd_i.ready)
    else $error("new request taken while a request is running");
`endif

endmodule
